// File: src/tkp_pkg.sv
package tkp_pkg;

    localparam int VOCAB_MAX = 1024;
    localparam int IDX_W     = $clog2(VOCAB_MAX);
    localparam int CNT_W     = IDX_W + 1;

    localparam int LOGIT_W   = 16;
    localparam int WEIGHT_W  = 24;
    localparam int TOTAL_W   = 34;
    localparam int PROD_W    = 50;
    localparam int NUM_W     = 37;
    localparam int SCALE_W   = 21;

    // 16 * log2(e) in Q16, so d*scale/t is d/T*log2(e) in Q.16
    localparam logic [SCALE_W-1:0] LOG2E_SCALED = 21'd1512768;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 24'hFFFFFF;

    // 2^-(1/2), 2^-(1/4), ... 2^-(1/256) in Q0.24
    localparam logic [WEIGHT_W-1:0] EXP_STEPS [8] = '{
        24'd11863283, 24'd14107902, 24'd15384775, 24'd16065917,
        24'd16417715, 24'd16596492, 24'd16686609, 24'd16731851
    };

    localparam logic [1:0] CFG_TEMPERATURE = 2'd0;
    localparam logic [1:0] CFG_TOP_K       = 2'd1;
    localparam logic [1:0] CFG_TOP_P       = 2'd2;

    localparam logic [15:0] TEMP_RESET = 16'd4096;
    localparam logic [16:0] TOPP_RESET = 17'd65536;

endpackage

// File: src/tkp_ram.sv
module tkp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/tkp_weight.sv
module tkp_weight (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tkp_pkg::LOGIT_W-1:0]   i_diff,
    input  logic [15:0]                   i_temp,
    output logic                          o_done,
    output logic [tkp_pkg::WEIGHT_W-1:0]  o_weight
);
    import tkp_pkg::*;

    typedef enum logic [3:0] {
        W_IDLE = 4'b0001,
        W_DIV  = 4'b0010,
        W_EXP  = 4'b0100,
        W_FIN  = 4'b1000
    } t_wstate;

    t_wstate            r_state, n_state;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [NUM_W-1:0]   r_q, n_q;
    logic [15:0]        r_rem, n_rem;
    logic [15:0]        r_t, n_t;
    logic [5:0]         r_cnt, n_cnt;
    logic [WEIGHT_W:0]  r_w, n_w;

    logic [16:0]        rem_sh;
    logic               q_bit;
    logic [7:0]         frac;
    logic [48:0]        step_prod;
    logic               too_small;
    logic [WEIGHT_W:0]  shifted;

    assign rem_sh    = {r_rem, r_num[NUM_W-1]};
    assign q_bit     = rem_sh >= {1'b0, r_t};
    assign frac      = r_q[15:8];
    assign step_prod = r_w * EXP_STEPS[r_cnt[2:0]];
    assign too_small = (r_q[NUM_W-1:21] != '0) || (r_q[20:16] >= 5'd25);
    assign shifted   = r_w >> r_q[20:16];

    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_q     = r_q;
        n_rem   = r_rem;
        n_t     = r_t;
        n_cnt   = r_cnt;
        n_w     = r_w;
        case (r_state)
            W_IDLE: begin
                if (i_start) begin
                    n_num   = NUM_W'(i_diff) * NUM_W'(LOG2E_SCALED);
                    n_t     = (i_temp == 16'd0) ? 16'd1 : i_temp;
                    n_rem   = '0;
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = W_DIV;
                end
            end
            W_DIV: begin
                // restoring divide, one quotient bit per cycle
                n_rem = q_bit ? 16'(rem_sh - {1'b0, r_t}) : rem_sh[15:0];
                n_q   = {r_q[NUM_W-2:0], q_bit};
                n_num = {r_num[NUM_W-2:0], 1'b0};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(NUM_W - 1)) begin
                    n_cnt   = '0;
                    n_w     = (WEIGHT_W+1)'(1) << WEIGHT_W;
                    n_state = W_EXP;
                end
            end
            W_EXP: begin
                if (frac[3'd7 - r_cnt[2:0]]) begin
                    n_w = step_prod[48:24];
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt[2:0] == 3'd7) begin
                    n_state = W_FIN;
                end
            end
            W_FIN: begin
                n_state = W_IDLE;
            end
            default: begin
                n_state = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_num <= n_num;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_t   <= n_t;
        r_w   <= n_w;
    end

    assign o_done   = (r_state == W_FIN);
    assign o_weight = too_small ? '0 :
                      (shifted > {1'b0, WEIGHT_MAX}) ? WEIGHT_MAX : shifted[WEIGHT_W-1:0];

endmodule

// File: src/top_k_top_p_token_sampler.sv
// Token sampler: logits (signed Q8.8) stream in on s_axis one per cycle and are
// stored in index order; the item with tlast also carries the Q0.16 random
// fraction and starts sampling, during which s_axis_tready is low. The sampled
// index is moved into an output register that drives m_axis, and the next vector
// is taken as soon as the index sits there; a new index waits until that register
// is free. For N stored logits, the weight pass reads each logit and hands it to
// the weight unit, a 37-step restoring divider and 8 steps of one table
// multiplier. With top-k/top-p on, a shift-add multiply forms the threshold and
// a max search over the weight memory marks each kept token; then a shift-add
// multiply forms the draw target, a scan of the kept weights draws the token and
// the output register is loaded. No clearing pass is needed after reset.
// Temperature, top-k and top-p are written on the cfg port, which is ready only
// while the block takes logits.
module top_k_top_p_token_sampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] logit_value, [31:16] random_fraction
    input  logic        s_axis_tlast,   // last_logit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] token_index, [15:10] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import tkp_pkg::*;

    typedef enum logic [9:0] {
        S_LOAD   = 10'b0000000001,
        S_WRD    = 10'b0000000010,
        S_WSTART = 10'b0000000100,
        S_WBUSY  = 10'b0000001000,
        S_PMUL   = 10'b0000010000,
        S_SCAN   = 10'b0000100000,
        S_MARK   = 10'b0001000000,
        S_RMUL   = 10'b0010000000,
        S_DRAW   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state                    r_state, n_state;
    logic [15:0]               r_temp;
    logic [CNT_W-1:0]          r_topk;
    logic [16:0]               r_topp;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic signed [LOGIT_W-1:0] r_max, n_max;
    logic [15:0]               r_rand, n_rand;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic [TOTAL_W-1:0]        r_wtot, n_wtot;
    logic [TOTAL_W-1:0]        r_ktot, n_ktot;
    logic [TOTAL_W-1:0]        r_acc, n_acc;
    logic [CNT_W-1:0]          r_kcnt, n_kcnt;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic [TOTAL_W-1:0]        r_mcand, n_mcand;
    logic [15:0]               r_mplier, n_mplier;
    logic [3:0]                r_mcnt, n_mcnt;
    logic                      r_rv, n_rv;
    logic [IDX_W-1:0]          r_ridx, n_ridx;
    logic                      r_found, n_found;
    logic [IDX_W-1:0]          r_best_idx, n_best_idx;
    logic [WEIGHT_W-1:0]       r_best_w, n_best_w;
    logic [IDX_W-1:0]          r_pick, n_pick;
    logic                      r_ovalid, n_ovalid;
    logic [IDX_W-1:0]          r_odata, n_odata;

    logic                      in_acc;
    logic                      cfg_acc;
    logic                      filter;
    logic signed [LOGIT_W-1:0] in_logit;
    logic [LOGIT_W-1:0]        logit_rdata;
    logic [WEIGHT_W:0]         wt_rdata;
    logic                      wt_we;
    logic [IDX_W-1:0]          wt_waddr;
    logic [WEIGHT_W:0]         wt_wdata;
    logic                      w_start;
    logic                      w_done;
    logic [WEIGHT_W-1:0]       w_weight;
    logic [LOGIT_W:0]          diff_ext;
    logic [TOTAL_W-1:0]        ktot_new;
    logic [CNT_W-1:0]          kcnt_new;
    logic [TOTAL_W-1:0]        acc_new;
    logic                      rd_kept;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign in_logit = s_axis_tdata[15:0];
    assign filter   = (r_topk != '0) || !r_topp[16];
    assign diff_ext = {r_max[LOGIT_W-1], r_max} - {logit_rdata[LOGIT_W-1], logit_rdata};
    assign ktot_new = r_ktot + TOTAL_W'(r_best_w);
    assign kcnt_new = r_kcnt + 1'b1;
    assign acc_new  = r_acc + TOTAL_W'(wt_rdata[WEIGHT_W-1:0]);
    assign rd_kept  = filter ? wt_rdata[WEIGHT_W] : 1'b1;

    tkp_ram #(.WIDTH(LOGIT_W), .DEPTH(VOCAB_MAX)) u_logit_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && !r_cnt[CNT_W-1]),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata (s_axis_tdata[15:0]),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (logit_rdata)
    );

    // weight memory entry: {keep mark, weight}
    tkp_ram #(.WIDTH(WEIGHT_W + 1), .DEPTH(VOCAB_MAX)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (wt_rdata)
    );

    tkp_weight u_weight (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_diff   (diff_ext[LOGIT_W-1:0]),
        .i_temp   (r_temp),
        .o_done   (w_done),
        .o_weight (w_weight)
    );

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_max      = r_max;
        n_rand     = r_rand;
        n_idx      = r_idx;
        n_wtot     = r_wtot;
        n_ktot     = r_ktot;
        n_acc      = r_acc;
        n_kcnt     = r_kcnt;
        n_prod     = r_prod;
        n_mcand    = r_mcand;
        n_mplier   = r_mplier;
        n_mcnt     = r_mcnt;
        n_rv       = 1'b0;
        n_ridx     = r_ridx;
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best_w   = r_best_w;
        n_pick     = r_pick;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_odata    = r_odata;
        w_start    = 1'b0;
        wt_we      = 1'b0;
        wt_waddr   = r_idx[IDX_W-1:0];
        wt_wdata   = {1'b0, w_weight};
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    // logits past the store size are dropped
                    if (!r_cnt[CNT_W-1]) begin
                        n_cnt = r_cnt + 1'b1;
                        if (in_logit > r_max) begin
                            n_max = in_logit;
                        end
                    end
                    if (s_axis_tlast) begin
                        n_rand  = s_axis_tdata[31:16];
                        n_idx   = '0;
                        n_wtot  = '0;
                        n_state = S_WRD;
                    end
                end
            end
            S_WRD: begin
                n_state = S_WSTART;
            end
            S_WSTART: begin
                w_start = 1'b1;
                n_state = S_WBUSY;
            end
            S_WBUSY: begin
                if (w_done) begin
                    wt_we  = 1'b1;
                    n_wtot = r_wtot + TOTAL_W'(w_weight);
                    n_idx  = r_idx + 1'b1;
                    n_prod   = '0;
                    n_mcnt   = '0;
                    n_mcand  = n_wtot;
                    if (n_idx == r_cnt) begin
                        if (filter) begin
                            n_mplier = r_topp[15:0];
                            n_state  = S_PMUL;
                        end else begin
                            n_mplier = r_rand;
                            n_state  = S_RMUL;
                        end
                    end else begin
                        n_state = S_WRD;
                    end
                end
            end
            S_PMUL, S_RMUL: begin
                // shared shift-add multiplier, multiplier msb first
                n_prod   = {r_prod[PROD_W-2:0], 1'b0}
                         + (r_mplier[15] ? PROD_W'(r_mcand) : '0);
                n_mplier = {r_mplier[14:0], 1'b0};
                n_mcnt   = r_mcnt + 1'b1;
                if (r_mcnt == 4'd15) begin
                    n_idx = '0;
                    if (r_state == S_PMUL) begin
                        n_found = 1'b0;
                        n_kcnt  = '0;
                        n_ktot  = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_acc   = '0;
                        n_state = S_DRAW;
                    end
                end
            end
            S_SCAN: begin
                if (r_rv && !wt_rdata[WEIGHT_W]
                        && (!r_found || wt_rdata[WEIGHT_W-1:0] > r_best_w)) begin
                    n_found    = 1'b1;
                    n_best_idx = r_ridx;
                    n_best_w   = wt_rdata[WEIGHT_W-1:0];
                end
                if (r_idx != r_cnt) begin
                    n_rv   = 1'b1;
                    n_ridx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                wt_we    = 1'b1;
                wt_waddr = r_best_idx;
                wt_wdata = {1'b1, r_best_w};
                n_ktot   = ktot_new;
                n_kcnt   = kcnt_new;
                n_idx    = '0;
                n_found  = 1'b0;
                if ((kcnt_new >= r_cnt)
                        || ((r_topk != '0) && (kcnt_new >= r_topk))
                        || (!r_topp[16] && ({ktot_new, 16'd0} >= r_prod))) begin
                    n_prod   = '0;
                    n_mcnt   = '0;
                    n_mcand  = ktot_new;
                    n_mplier = r_rand;
                    n_state  = S_RMUL;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DRAW: begin
                if (r_rv && rd_kept && (wt_rdata[WEIGHT_W-1:0] != '0)) begin
                    n_acc = acc_new;
                end
                if (r_rv && rd_kept && (wt_rdata[WEIGHT_W-1:0] != '0)
                        && (r_prod <= {acc_new, 16'd0})) begin
                    n_pick  = r_ridx;
                    n_state = S_OUT;
                end else if (r_idx != r_cnt) begin
                    n_rv   = 1'b1;
                    n_ridx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + 1'b1;
                end else begin
                    // nothing drawn: last stored index
                    n_pick  = IDX_W'(r_cnt - 1'b1);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the output register to be free
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_pick;
                    n_cnt    = '0;
                    n_max    = {1'b1, {(LOGIT_W-1){1'b0}}};
                    n_state  = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_temp   <= TEMP_RESET;
            r_topk   <= '0;
            r_topp   <= TOPP_RESET;
            r_cnt    <= '0;
            r_max    <= {1'b1, {(LOGIT_W-1){1'b0}}};
            r_rv     <= 1'b0;
            r_found  <= 1'b0;
            r_mcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_max    <= n_max;
            r_rv     <= n_rv;
            r_found  <= n_found;
            r_mcnt   <= n_mcnt;
            r_ovalid <= n_ovalid;
            if (cfg_acc) begin
                case (i_cfg_index)
                    CFG_TEMPERATURE: r_temp <= i_cfg_data[15:0];
                    CFG_TOP_K:       r_topk <= i_cfg_data[CNT_W-1:0];
                    CFG_TOP_P:       r_topp <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_rand     <= n_rand;
        r_idx      <= n_idx;
        r_wtot     <= n_wtot;
        r_ktot     <= n_ktot;
        r_acc      <= n_acc;
        r_kcnt     <= n_kcnt;
        r_prod     <= n_prod;
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_ridx     <= n_ridx;
        r_best_idx <= n_best_idx;
        r_best_w   <= n_best_w;
        r_pick     <= n_pick;
        r_odata    <= n_odata;
    end

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {(16 - IDX_W)'(0), r_odata};
    assign o_cfg_ready   = (r_state == S_LOAD);

endmodule

// File: src/tkp_checker.sv
module tkp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // no result shows right after a reset cycle
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // the last item starts sampling, so input stalls next cycle
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still ready after last item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:10] == 6'd0))
        else $error("result padding not zero");

endmodule

bind top_k_top_p_token_sampler tkp_checker u_tkp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
